[src/assert_macros.svh]
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication under reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication under reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[src/s2x_pkg.sv]
package s2x_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int PIX_W    = 32;
    localparam int WREG_W   = 11;
    localparam int HREG_W   = 13;
    localparam int CFG_W    = 13;
    localparam int CFG_A_W  = 1;
    localparam int OCOL_W   = 10;
    localparam int OROW_W   = 12;

    localparam logic [WREG_W-1:0] WIDTH_RESET  = WREG_W'(1024);
    localparam logic [HREG_W-1:0] HEIGHT_RESET = HREG_W'(1024);

    // register indexes on the config port
    localparam logic [CFG_A_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_A_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // beat kinds on s_tuser
    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // neighbourhood of one source pixel plus its tags
    typedef struct packed {
        logic [PIX_W-1:0]  b;
        logic [PIX_W-1:0]  d;
        logic [PIX_W-1:0]  e;
        logic [PIX_W-1:0]  f;
        logic [PIX_W-1:0]  h;
        logic [OCOL_W-1:0] col;
        logic [OROW_W-1:0] row;
        logic              eof;
    } blk_t;

    // one expanded 2x2 block
    typedef struct packed {
        logic [PIX_W-1:0]  tl;
        logic [PIX_W-1:0]  tr;
        logic [PIX_W-1:0]  bl;
        logic [PIX_W-1:0]  br;
        logic [OCOL_W-1:0] col;
        logic [OROW_W-1:0] row;
        logic              eof;
    } res_t;

    // beat in flight between store read and blend
    typedef struct packed {
        logic              valid;
        logic              sel;
        logic              d_from_e;
        logic              b_is_e;
        logic              h_is_e;
        logic [PIX_W-1:0]  pix;
        logic [OCOL_W-1:0] col;
        logic [OROW_W-1:0] row;
        logic              eof;
    } s1_t;

endpackage

[src/s2x_line_store.sv]
module s2x_line_store #(
    parameter int DEPTH = s2x_pkg::MAX_WIDTH_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [ADDR_W-1:0]        wr_addr,
    input  logic [s2x_pkg::PIX_W-1:0] wr_data,
    input  logic                     rd_en,
    input  logic [ADDR_W-1:0]        rd_addr0,
    input  logic [ADDR_W-1:0]        rd_addr1,
    output logic [s2x_pkg::PIX_W-1:0] rd_data0,
    output logic [s2x_pkg::PIX_W-1:0] rd_data1
);

    logic [s2x_pkg::PIX_W-1:0] mem [DEPTH];

    // reads see the old word when the same entry is written in the same cycle
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data0 <= mem[rd_addr0];
            rd_data1 <= mem[rd_addr1];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

[src/s2x_blend.sv]
`include "assert_macros.svh"

module s2x_blend (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  s2x_pkg::blk_t     in_blk,
    output logic              out_valid,
    input  logic              out_ready,
    output s2x_pkg::res_t     out_res
);

    logic          valid_reg;
    s2x_pkg::res_t res_reg;
    s2x_pkg::res_t res_next;
    logic          edge_case;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        edge_case    = (in_blk.b != in_blk.h) && (in_blk.d != in_blk.f);
        res_next.tl  = in_blk.e;
        res_next.tr  = in_blk.e;
        res_next.bl  = in_blk.e;
        res_next.br  = in_blk.e;
        if (edge_case) begin
            res_next.tl = (in_blk.d == in_blk.b) ? in_blk.d : in_blk.e;
            res_next.tr = (in_blk.b == in_blk.f) ? in_blk.f : in_blk.e;
            res_next.bl = (in_blk.d == in_blk.h) ? in_blk.d : in_blk.e;
            res_next.br = (in_blk.h == in_blk.f) ? in_blk.f : in_blk.e;
        end
        res_next.col = in_blk.col;
        res_next.row = in_blk.row;
        res_next.eof = in_blk.eof;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    `ASSERT_NEXT(a_blend_load, aclk, aresetn, in_valid && in_ready, valid_reg)
    `ASSERT_IMPLY(a_blend_block, aclk, aresetn, valid_reg && !out_ready, !in_ready)

endmodule

[src/scale2x_pixel_upscaler.sv]
// Scale2x 2x pixel upscaler. Source pixels enter in raster order as push beats
// (s_tuser = 0, pixel in s_tdata); each source pixel leaves as one 2x2 block on
// m_tdata, with neighbours past the image edge clamped to the edge pixel. The
// block of row y comes out when the pixel of row y+1 in the same column is
// pushed, so row 0 pushes give no block. After the final pixel of a frame the
// last row is fetched by drain beats (s_tuser = 1), one block each; m_tlast
// marks the final block of the frame. Push beats during draining and drain beats
// outside it are taken and dropped. Throughput is one beat per clock unless a
// stalled block holds the input; a block passes the line store read and then
// the output register. Two line stores of MAX_WIDTH words, each with one write
// port and two read ports (centre column and right neighbour), set that rate:
// every beat does its reads and its write in the same cycle, and the left
// neighbour is the centre word kept from the previous beat. The stores need no
// clearing after reset. A width or height write counts from the next beat on,
// and the position within the frame is kept.
`include "assert_macros.svh"

module scale2x_pixel_upscaler #(
    parameter int MAX_WIDTH  = s2x_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = s2x_pkg::MAX_HEIGHT_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // config write port
    input  logic                       cfg_wr_en,
    input  logic [s2x_pkg::CFG_A_W-1:0] cfg_addr,
    input  logic [s2x_pkg::CFG_W-1:0]  cfg_wdata,
    // source beats
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [31:0]                s_tdata,   // pixel_in
    input  logic [0:0]                 s_tuser,   // command
    // block beats
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // out_top_left, out_top_right, out_bottom_left, out_bottom_right,
    // source_column, source_row, zero pad
    output logic [151:0]               m_tdata,
    output logic                       m_tlast    // end_of_frame
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // position and frame state
    logic                         sel_reg, sel_next;
    logic [COL_W-1:0]             col_reg, col_next;
    logic [ROW_W-1:0]             row_reg, row_next;
    logic                         draining_reg, draining_next;
    logic [s2x_pkg::WREG_W-1:0]   width_reg;
    logic [s2x_pkg::HREG_W-1:0]   height_reg;

    // stage between store read and blend
    s2x_pkg::s1_t                 s1_reg;
    logic [s2x_pkg::PIX_W-1:0]    d_reg;

    logic [31:0] w_eff, h_eff, x32, xp32, row32;
    logic [COL_W-1:0] xp;
    logic last_col, last_row;
    logic accept, push, drain, active, emit;

    logic we_a, we_b;
    logic [s2x_pkg::PIX_W-1:0] a_rd0, a_rd1, b_rd0, b_rd1;
    logic [s2x_pkg::PIX_W-1:0] e_cur, f_cur, b_cur;

    s2x_pkg::blk_t blk;
    s2x_pkg::res_t res;
    logic          blend_ready;

    // register values clamped into their legal range
    always_comb begin
        if (width_reg == '0) begin
            w_eff = 32'd1;
        end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
            w_eff = 32'(MAX_WIDTH);
        end else begin
            w_eff = 32'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = 32'd1;
        end else if (32'(height_reg) > 32'(MAX_HEIGHT)) begin
            h_eff = 32'(MAX_HEIGHT);
        end else begin
            h_eff = 32'(height_reg);
        end
    end

    // neighbour addressing: right neighbour clamped at the row end
    assign x32      = 32'(col_reg);
    assign row32    = 32'(row_reg);
    assign last_col = (x32 + 32'd1) >= w_eff;
    assign last_row = (row32 + 32'd1) >= h_eff;
    assign xp32     = last_col ? x32 : x32 + 32'd1;
    assign xp       = xp32[COL_W-1:0];

    // a stalled block in stage one holds the input
    assign s_tready = !s1_reg.valid || blend_ready;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && (s_tuser[0] == s2x_pkg::CMD_PUSH) && !draining_reg;
    assign drain    = accept && (s_tuser[0] == s2x_pkg::CMD_DRAIN) && draining_reg;
    assign active   = push || drain;
    assign emit     = drain || (push && row_reg != '0);

    // the store under write holds the row two above, the other the row above
    assign we_a = push && !sel_reg;
    assign we_b = push && sel_reg;

    always_comb begin
        sel_next      = sel_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        draining_next = draining_reg;
        if (drain) begin
            if (last_col) begin
                draining_next = 1'b0;
                col_next      = '0;
                row_next      = '0;
            end else begin
                col_next = COL_W'(x32 + 32'd1);
            end
        end else if (push) begin
            if (last_col) begin
                col_next = '0;
                sel_next = !sel_reg;
                if (last_row) begin
                    draining_next = 1'b1;
                end else begin
                    row_next = ROW_W'(row32 + 32'd1);
                end
            end else begin
                col_next = COL_W'(x32 + 32'd1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg      <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
            draining_reg <= 1'b0;
            width_reg    <= s2x_pkg::WIDTH_RESET;
            height_reg   <= s2x_pkg::HEIGHT_RESET;
            s1_reg.valid <= 1'b0;
        end else begin
            sel_reg      <= sel_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            draining_reg <= draining_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    s2x_pkg::REG_IMAGE_WIDTH: begin
                        width_reg <= cfg_wdata[s2x_pkg::WREG_W-1:0];
                    end
                    s2x_pkg::REG_IMAGE_HEIGHT: begin
                        height_reg <= cfg_wdata[s2x_pkg::HREG_W-1:0];
                    end
                endcase
            end
            if (accept) begin
                s1_reg.valid <= emit;
            end else if (blend_ready) begin
                s1_reg.valid <= 1'b0;
            end
        end
        // payload of stage one, loaded with the store read
        if (active) begin
            d_reg           <= e_cur;
            s1_reg.sel      <= sel_reg;
            s1_reg.d_from_e <= (col_reg == '0);
            s1_reg.b_is_e   <= drain ? (row_reg == '0) : (row32 == 32'd1);
            s1_reg.h_is_e   <= drain;
            s1_reg.pix      <= s_tdata;
            s1_reg.col      <= s2x_pkg::OCOL_W'(x32);
            s1_reg.row      <= drain ? s2x_pkg::OROW_W'(row32)
                                     : s2x_pkg::OROW_W'(row32 - 32'd1);
            s1_reg.eof      <= drain && last_col;
        end
    end

    s2x_line_store #(.DEPTH(MAX_WIDTH)) u_store_a (
        .aclk     (aclk),
        .wr_en    (we_a),
        .wr_addr  (col_reg),
        .wr_data  (s_tdata),
        .rd_en    (active),
        .rd_addr0 (col_reg),
        .rd_addr1 (xp),
        .rd_data0 (a_rd0),
        .rd_data1 (a_rd1)
    );

    s2x_line_store #(.DEPTH(MAX_WIDTH)) u_store_b (
        .aclk     (aclk),
        .wr_en    (we_b),
        .wr_addr  (col_reg),
        .wr_data  (s_tdata),
        .rd_en    (active),
        .rd_addr0 (col_reg),
        .rd_addr1 (xp),
        .rd_data0 (b_rd0),
        .rd_data1 (b_rd1)
    );

    // read data sorted by role, using the select of the beat in stage one
    assign e_cur = s1_reg.sel ? a_rd0 : b_rd0;
    assign f_cur = s1_reg.sel ? a_rd1 : b_rd1;
    assign b_cur = s1_reg.sel ? b_rd0 : a_rd0;

    always_comb begin
        blk.e   = e_cur;
        blk.f   = f_cur;
        blk.b   = s1_reg.b_is_e ? e_cur : b_cur;
        blk.d   = s1_reg.d_from_e ? e_cur : d_reg;
        blk.h   = s1_reg.h_is_e ? e_cur : s1_reg.pix;
        blk.col = s1_reg.col;
        blk.row = s1_reg.row;
        blk.eof = s1_reg.eof;
    end

    s2x_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_reg.valid),
        .in_ready  (blend_ready),
        .in_blk    (blk),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {2'b00, res.row, res.col, res.br, res.bl, res.tr, res.tl};
    assign m_tlast = res.eof;

    // no row store is written while the last row is drained
    `ASSERT_IMPLY(a_no_write_drain, aclk, aresetn, draining_reg, !we_a && !we_b)
    // the final drain block closes the frame
    `ASSERT_NEXT(a_drain_end, aclk, aresetn, drain && last_col,
                 !draining_reg && col_reg == '0 && row_reg == '0)
    // row zero pushes only fill the store
    `ASSERT_NEXT(a_row0_quiet, aclk, aresetn, push && row_reg == '0, !s1_reg.valid)
    // a row end always flips the store roles
    `ASSERT_NEXT(a_flip_on_row, aclk, aresetn, push && last_col, sel_reg != $past(sel_reg))

endmodule
